@@ rtl/mei_pkg.sv @@
// Shared types, constants and helpers of the Mandelbrot escape-time block.
// Used by every module under rtl; depends on nothing else.
package mei_pkg;

    localparam int FRAC_BITS_DEF  = 28;
    localparam int PIXEL_BITS_DEF = 12;

    localparam int PIX_FIELD_W = 12;
    localparam int COORD_W     = 32;
    localparam int STEP_W      = 31;
    localparam int COUNT_W     = 10;
    localparam int SHADE_W     = 8;
    localparam int PROD_W      = 64;
    localparam int WIDE_W      = 66;
    localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap on their own
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [SHADE_W-1:0] SHADE_WHITE = 8'd255;
    localparam logic [SHADE_W-1:0] SHADE_BLACK = 8'd0;

    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_RE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_IM = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_RE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_IM   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITER  = 3'd4;

    localparam logic signed [COORD_W-1:0] ORIGIN_RE_RST = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] ORIGIN_IM_RST = -32'sd402653184;
    localparam logic [STEP_W-1:0]         STEP_RE_RST   = 31'd786432;
    localparam logic [STEP_W-1:0]         STEP_IM_RST   = 31'd786432;
    localparam logic [COUNT_W-1:0]        MAX_ITER_RST  = 10'd64;

    typedef struct packed {
        logic [PIX_FIELD_W-1:0] pixel_x;
        logic [PIX_FIELD_W-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [COUNT_W-1:0] iteration_count;
        logic               inside_res;
        logic [SHADE_W-1:0] shade;
    } t_res;

    // One mapped point c, as handed from the front end to the engine.
    typedef struct packed {
        logic signed [COORD_W-1:0] c_re;
        logic signed [COORD_W-1:0] c_im;
    } t_point;

    // Plane mapping settings seen by the front end.
    typedef struct packed {
        logic signed [COORD_W-1:0] origin_re;
        logic signed [COORD_W-1:0] origin_im;
        logic [STEP_W-1:0]         step_re;
        logic [STEP_W-1:0]         step_im;
    } t_map_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_WAIT
    } t_eng_state;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-COORD_W:0] top;
        logic signed [COORD_W-1:0] res;
        top = v[WIDE_W-1:COORD_W-1];
        if (top == '0 || top == '1) begin
            res = v[COORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ rtl/mei_front.sv @@
// Front end: accepts pixel words and maps them to plane points c.
// Two stages (multiply, then add and clamp); depends on mei_pkg.
module mei_front import mei_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_pix_valid,
    input  t_pix_in  i_pix,
    output logic     o_pix_stall,
    input  t_map_cfg i_map_cfg,
    output logic     o_push,
    output t_point   o_point,
    input  logic     i_full
);
    localparam int PX_W   = (PIXEL_BITS < PIX_FIELD_W) ? PIXEL_BITS : PIX_FIELD_W;
    localparam int MAP_W  = PX_W + STEP_W;

    logic [PX_W-1:0]  px;
    logic [PX_W-1:0]  py;
    logic             s1_move;
    logic             s2_move;
    logic             accept;
    logic             r_s1_valid;
    logic [MAP_W-1:0] r_prod_re;
    logic [MAP_W-1:0] r_prod_im;
    logic             r_s2_valid;
    t_point           r_s2_point;
    logic signed [WIDE_W-1:0] sum_re;
    logic signed [WIDE_W-1:0] sum_im;

    // Only the low PIXEL_BITS bits of a coordinate take part (at most the whole field).
    assign px = i_pix.pixel_x[PX_W-1:0];
    assign py = i_pix.pixel_y[PX_W-1:0];

    assign s2_move     = !r_s2_valid || !i_full;
    assign s1_move     = !r_s1_valid || s2_move;
    assign accept      = i_pix_valid && s1_move;
    assign o_pix_stall = !s1_move;
    assign o_push      = r_s2_valid && !i_full;
    assign o_point     = r_s2_point;

    assign sum_re = WIDE_W'(i_map_cfg.origin_re) + $signed({{(WIDE_W-MAP_W){1'b0}}, r_prod_re});
    assign sum_im = WIDE_W'(i_map_cfg.origin_im) + $signed({{(WIDE_W-MAP_W){1'b0}}, r_prod_im});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_s1_valid <= accept;
            end
            if (s2_move) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_re <= MAP_W'(px) * MAP_W'(i_map_cfg.step_re);
            r_prod_im <= MAP_W'(py) * MAP_W'(i_map_cfg.step_im);
        end
        if (s2_move && r_s1_valid) begin
            r_s2_point.c_re <= sat32(sum_re);
            r_s2_point.c_im <= sat32(sum_im);
        end
    end

endmodule

@@ rtl/mei_queue.sv @@
// Short queue of mapped points between the front end and the engine.
// Register array with wrapping pointers and a fill count; depends on mei_pkg.
module mei_queue import mei_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_point i_point,
    output logic   o_full,
    input  logic   i_pop,
    output t_point o_head,
    output logic   o_empty
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_point           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_fill;

    assign o_full  = (r_fill == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_point;
        end
    end

endmodule

@@ rtl/mei_back.sv @@
// Iteration engine: runs z = z*z + c for one point and registers the result word.
// Sequencer over three shared multipliers and one update stage; depends on mei_pkg.
module mei_back import mei_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_point             i_head,
    output logic               o_pop,
    input  logic [COUNT_W-1:0] i_max_iter,
    output logic               o_res_valid,
    output t_res               o_res,
    input  logic               i_res_stall
);
    localparam logic [PROD_W-1:0] LIMIT = PROD_W'(1) << (2*FRAC_BITS + 2);

    t_eng_state r_state;
    t_eng_state n_state;

    logic mul_en;
    logic upd_en;
    logic finish;
    logic out_free;
    logic out_load;
    logic done;
    logic escape;

    logic signed [COORD_W-1:0] r_c_re;
    logic signed [COORD_W-1:0] r_c_im;
    logic signed [COORD_W-1:0] r_re;
    logic signed [COORD_W-1:0] r_im;
    logic signed [PROD_W-1:0]  r_rr;
    logic signed [PROD_W-1:0]  r_ii;
    logic signed [PROD_W-1:0]  r_ri;
    logic [COUNT_W-1:0]        r_count;
    logic                      r_out_valid;
    t_res                      r_out;

    logic signed [PROD_W-1:0]  rr_full;
    logic signed [PROD_W-1:0]  ii_full;
    logic signed [PROD_W-1:0]  ri_full;
    logic [PROD_W-1:0]         mag;
    logic signed [PROD_W:0]    diff;
    logic signed [PROD_W:0]    diff_sh;
    logic signed [PROD_W-1:0]  ri_sh;
    logic signed [WIDE_W-1:0]  nre_wide;
    logic signed [WIDE_W-1:0]  nim_wide;
    logic                      res_inside;

    assign rr_full = r_re * r_re;
    assign ii_full = r_im * r_im;
    assign ri_full = r_re * r_im;

    // Both squares are non-negative, so the magnitude sum fits 64 bits unsigned.
    assign mag    = r_rr + r_ii;
    assign escape = (mag >= LIMIT);
    assign done   = (r_count >= i_max_iter) || escape;

    // Arithmetic shifts give the floor of the scaled products.
    assign diff     = {r_rr[PROD_W-1], r_rr} - {r_ii[PROD_W-1], r_ii};
    assign diff_sh  = diff >>> FRAC_BITS;
    assign ri_sh    = r_ri >>> (FRAC_BITS - 1);
    assign nre_wide = WIDE_W'(diff_sh) + WIDE_W'(r_c_re);
    assign nim_wide = WIDE_W'(ri_sh) + WIDE_W'(r_c_im);

    assign out_free   = !r_out_valid || !i_res_stall;
    assign out_load   = finish && out_free;
    assign res_inside = (r_count == i_max_iter);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!done) begin
                    n_state = S_MUL;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        mul_en = 1'b0;
        upd_en = 1'b0;
        finish = 1'b0;
        unique case (r_state)
            S_IDLE: o_pop = !i_empty;
            S_MUL:  mul_en = 1'b1;
            S_UPD: begin
                finish = done;
                upd_en = !done;
            end
            S_WAIT: finish = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_c_re  <= i_head.c_re;
            r_c_im  <= i_head.c_im;
            r_re    <= i_head.c_re;
            r_im    <= i_head.c_im;
            r_count <= '0;
        end
        if (mul_en) begin
            r_rr <= rr_full;
            r_ii <= ii_full;
            r_ri <= ri_full;
        end
        if (upd_en) begin
            r_re    <= sat32(nre_wide);
            r_im    <= sat32(nim_wide);
            r_count <= r_count + 1'b1;
        end
        if (out_load) begin
            r_out.iteration_count <= r_count;
            r_out.inside_res      <= res_inside;
            r_out.shade           <= res_inside ? SHADE_BLACK : SHADE_WHITE;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`ifndef SYNTHESIS
    a_upd_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |-> $past(r_state) == S_MUL)
        else $error("update stage entered without a multiply cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD || r_state == S_WAIT) |-> r_count <= i_max_iter)
        else $error("iteration count ran past the limit");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_en |=> r_count == $past(r_count) + 1'b1)
        else $error("iteration count did not advance by one");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_UPD || $past(r_state) == S_WAIT))
        else $error("result word produced outside the finishing states");
`endif

endmodule

@@ rtl/mandelbrot_escape_iteration.sv @@
// Top level of the Mandelbrot escape-time block: configuration registers and wiring.
// Instantiates mei_front, mei_queue and mei_back; depends on mei_pkg.
//
//  channel  direction  handshake                    word
//  pixel    in         i_pix_valid / o_pix_stall    t_pix_in (pixel_x, pixel_y)
//  result   out        o_res_valid / i_res_stall    t_res (count, inside, shade)
//  config   in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// The engine loads a point in its idle state, then spends a multiply state and an
// update state on each escape test. The front end's multiply and add stages overlap
// with the engine's work.
// Reset is synchronous and restores the default plane and iteration limit.
// A stalled result holds in the output register while the engine starts the
// next point; the two-entry point queue lets the front end keep accepting.
module mandelbrot_escape_iteration import mei_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_pix_valid,
    input  t_pix_in                i_pix,
    output logic                   o_pix_stall,
    output logic                   o_res_valid,
    output t_res                   o_res,
    input  logic                   i_res_stall,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);
    t_map_cfg           r_map_cfg;
    logic [COUNT_W-1:0] r_max_iter;
    logic               cfg_we;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_point front_point;
    t_point head_point;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Writes to indexes past the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_cfg.origin_re <= ORIGIN_RE_RST;
            r_map_cfg.origin_im <= ORIGIN_IM_RST;
            r_map_cfg.step_re   <= STEP_RE_RST;
            r_map_cfg.step_im   <= STEP_IM_RST;
            r_max_iter          <= MAX_ITER_RST;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_RE: r_map_cfg.origin_re <= i_cfg_data;
                CFG_ORIGIN_IM: r_map_cfg.origin_im <= i_cfg_data;
                CFG_STEP_RE:   r_map_cfg.step_re   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_IM:   r_map_cfg.step_im   <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_ITER:  r_max_iter          <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    mei_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .i_pix       (i_pix),
        .o_pix_stall (o_pix_stall),
        .i_map_cfg   (r_map_cfg),
        .o_push      (push),
        .o_point     (front_point),
        .i_full      (full)
    );

    mei_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_point (front_point),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head_point),
        .o_empty (empty)
    );

    mei_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head_point),
        .o_pop       (pop),
        .i_max_iter  (r_max_iter),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (i_res_stall)
    );

endmodule

@@ tb/tb_mandelbrot_escape_iteration.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for mandelbrot_escape_iteration: streams pixel words through
// the block and checks each result word against an internal fixed-point escape-time model.
// Depends on mei_pkg and the RTL top level under rtl.
module tb_mandelbrot_escape_iteration;
    import mei_pkg::*;

    localparam int          FRAC             = FRAC_BITS_DEF;
    localparam int          PIX_BITS         = PIXEL_BITS_DEF;
    localparam longint      PIX_MASK         = (64'sd1 << PIX_BITS) - 1;
    localparam longint      ONE              = 64'sd1 << FRAC;
    localparam longint      S32_MAX          = 64'sd2147483647;
    localparam longint      S32_MIN          = -64'sd2147483648;
    localparam logic [63:0] ESCAPE_RADIUS_SQ = 64'd4 << (2 * FRAC);
    localparam int          PIX_FULL         = (1 << PIX_FIELD_W) - 1;
    localparam int          WATCHDOG_LIMIT   = 30000;
    localparam int          PHASES           = 12;
    localparam int          PHASE_PIXELS     = 155;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_pix_valid = 1'b0;
    t_pix_in                i_pix       = '0;
    logic                   o_pix_stall;
    logic                   o_res_valid;
    t_res                   o_res;
    logic                   i_res_stall = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // Plane settings as the block should currently hold them.
    logic signed [COORD_W-1:0] plane_origin_re = ORIGIN_RE_RST;
    logic signed [COORD_W-1:0] plane_origin_im = ORIGIN_IM_RST;
    logic [STEP_W-1:0]         plane_step_re   = STEP_RE_RST;
    logic [STEP_W-1:0]         plane_step_im   = STEP_IM_RST;
    logic [COUNT_W-1:0]        iter_limit      = MAX_ITER_RST;

    t_pix_in pixel_q[$];
    t_res    escape_q[$];

    int   error_count    = 0;
    int   pixels_planned = 0;
    int   pixels_sent    = 0;
    int   results_seen   = 0;
    int   inside_seen    = 0;
    int   planes_used    = 0;
    int   idle_cycles    = 0;
    int   sender_gap_pct = 0;
    int   recv_stall_pct = 0;
    logic pix_accepted   = 1'b0;

    wire pix_fire = i_rst_n && i_pix_valid && !o_pix_stall;
    wire res_fire = i_rst_n && o_res_valid && !i_res_stall;
    wire cfg_fire = i_rst_n && i_cfg_valid && o_cfg_ready;

    mandelbrot_escape_iteration DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .i_pix       (i_pix),
        .o_pix_stall (o_pix_stall),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (i_res_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp32(input longint v);
        if (v > S32_MAX) begin
            return S32_MAX;
        end else if (v < S32_MIN) begin
            return S32_MIN;
        end
        return v;
    endfunction

    // Maps the pixel onto the plane and runs z = z*z + c until escape or the limit.
    function automatic t_res predict_escape(input t_pix_in pix);
        longint      px, py, c_re, c_im, re, im, nre, nim;
        logic [63:0] mag_re, mag_im;
        int unsigned count;
        logic        escaped;
        t_res        r;
        px      = longint'(pix.pixel_x) & PIX_MASK;
        py      = longint'(pix.pixel_y) & PIX_MASK;
        c_re    = clamp32(longint'(plane_origin_re) + px * longint'(plane_step_re));
        c_im    = clamp32(longint'(plane_origin_im) + py * longint'(plane_step_im));
        re      = c_re;
        im      = c_im;
        count   = 0;
        escaped = 1'b0;
        while (count < iter_limit && !escaped) begin
            mag_re = (re < 0) ? -re : re;
            mag_im = (im < 0) ? -im : im;
            if (mag_re * mag_re + mag_im * mag_im >= ESCAPE_RADIUS_SQ) begin
                escaped = 1'b1;
            end else begin
                // An arithmetic shift of a signed value is a floor division.
                nre   = ((re * re - im * im) >>> FRAC) + c_re;
                nim   = ((2 * re * im) >>> FRAC) + c_im;
                re    = clamp32(nre);
                im    = clamp32(nim);
                count = count + 1;
            end
        end
        r.iteration_count = COUNT_W'(count);
        r.inside_res      = (count == iter_limit);
        r.shade           = r.inside_res ? SHADE_BLACK : SHADE_WHITE;
        return r;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Pixel driver: a word is replaced only once the block has taken it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pix_valid <= 1'b0;
        end else if (!i_pix_valid || pix_accepted) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                i_pix_valid <= 1'b1;
                i_pix       <= pixel_q.pop_front();
            end else begin
                i_pix_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_res_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        pix_accepted <= pix_fire;
        if (pix_fire) begin
            escape_q.push_back(predict_escape(i_pix));
            pixels_sent++;
        end
        if (res_fire) begin
            results_seen++;
            if (escape_q.size() == 0) begin
                error_count++;
                $display({"%0t: unexpected result word, expected none, ",
                          "actual count %0d inside %0b shade %0d"},
                         $time, o_res.iteration_count, o_res.inside_res, o_res.shade);
            end else begin
                want = escape_q.pop_front();
                if (want.inside_res) begin
                    inside_seen++;
                end
                report_field("iteration_count", int'(want.iteration_count),
                             int'(o_res.iteration_count));
                report_field("inside_res", int'(want.inside_res), int'(o_res.inside_res));
                report_field("shade", int'(want.shade), int'(o_res.shade));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || pix_fire || res_fire || cfg_fire) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ORIGIN_RE: plane_origin_re = data;
            CFG_ORIGIN_IM: plane_origin_im = data;
            CFG_STEP_RE:   plane_step_re   = data[STEP_W-1:0];
            CFG_STEP_IM:   plane_step_im   = data[STEP_W-1:0];
            CFG_MAX_ITER:  iter_limit      = data[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_plane(input logic [31:0] ore, input logic [31:0] oim,
                               input logic [31:0] sre, input logic [31:0] sim,
                               input logic [31:0] maxit);
        write_reg(CFG_ORIGIN_RE, ore);
        write_reg(CFG_ORIGIN_IM, oim);
        write_reg(CFG_STEP_RE, sre);
        write_reg(CFG_STEP_IM, sim);
        write_reg(CFG_MAX_ITER, maxit);
        planes_used++;
    endtask

    task automatic send_pixel(input int x, input int y);
        t_pix_in p;
        p.pixel_x = PIX_FIELD_W'(x);
        p.pixel_y = PIX_FIELD_W'(y);
        pixel_q.push_back(p);
        pixels_planned++;
    endtask

    // Holds off the next step until every queued word has gone in and come back.
    task automatic drain_results();
        @(negedge i_clk);
        while (pixels_sent != pixels_planned || escape_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Most pixels fall in a window at the low corner of the screen, the rest anywhere.
    task automatic send_random_pixel(input int span);
        if ($urandom_range(3) != 0) begin
            send_pixel($urandom_range(span), $urandom_range(span));
        end else begin
            send_pixel($urandom_range(PIX_FULL), $urandom_range(PIX_FULL));
        end
    endtask

    task automatic run_phase(input t_idle_mode mode, input int count, input int span);
        sender_gap_pct = (mode == IDLE_SENDER) ? 47 : (mode == IDLE_BOTH) ? 38 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 47 : (mode == IDLE_BOTH) ? 38 : 0;
        repeat (count / 2) send_random_pixel(span);
        drain_results();
        repeat (count - count / 2) send_random_pixel(span);
        drain_results();
    endtask

    // Style 0 jitters the default view, style 1 zooms somewhere near the set,
    // style 2 takes arbitrary register values.
    task automatic pick_plane(input int style, output int span);
        longint step, cx, cy;
        case (style)
            0: begin
                step = 786432 + longint'($urandom_range(65536)) - 32768;
                write_plane(32'(-2 * ONE + longint'($urandom_range(1 << 25)) - (1 << 24)),
                            32'(-ONE - ONE / 2 + longint'($urandom_range(1 << 25)) - (1 << 24)),
                            32'(step), 32'(step + longint'($urandom_range(4096))),
                            $urandom_range(16, 128));
                span = 1023;
            end
            1: begin
                step = longint'($urandom_range(64, 400000));
                cx   = longint'($urandom_range(32'(5 * ONE / 2))) - 2 * ONE;
                cy   = longint'($urandom_range(32'(12 * ONE / 5))) - 6 * ONE / 5;
                write_plane(32'(cx - 2048 * step), 32'(cy - 2048 * step), 32'(step), 32'(step),
                            $urandom_range(1, 128));
                span = PIX_FULL;
            end
            default: begin
                write_plane($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 1023));
                span = PIX_FULL;
            end
        endcase
    endtask

    initial begin : stimulus
        int span;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset plane: screen corners, alternating bit patterns and a point near the origin.
        send_pixel(0, 0);
        send_pixel(PIX_FULL, PIX_FULL);
        send_pixel(0, PIX_FULL);
        send_pixel(PIX_FULL, 0);
        send_pixel(683, 512);
        send_pixel(32'hAAA, 32'hAAA);
        send_pixel(32'h555, 32'h555);
        drain_results();

        // Zero limit, written with junk above the field; unused indexes must be ignored.
        write_reg(CFG_MAX_ITER, 32'hFFFF_FC00);
        for (int k = CFG_MAX_ITER + 1; k < (1 << CFG_INDEX_W); k++) begin
            write_reg(CFG_INDEX_W'(k), $urandom);
        end
        send_pixel(683, 512);
        send_pixel(0, 0);
        drain_results();

        // Extreme origins and steps so the mapping reaches both ends and saturates at the top.
        write_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1);
        send_pixel(PIX_FULL, PIX_FULL);
        send_pixel(0, 0);
        send_pixel(1, 1);
        drain_results();

        // c = 0 never escapes, so these run to the largest limit.
        write_plane(32'd0, 32'd0, 32'd0, 32'd0, 32'd1023);
        send_pixel(PIX_FULL, 0);
        send_pixel(0, PIX_FULL);
        drain_results();

        // c = -2 sits exactly on the escape radius.
        write_reg(CFG_ORIGIN_RE, 32'(-2 * ONE));
        send_pixel(7, 9);
        drain_results();

        // c = 1/4 creeps toward the fixed point at 1/2 without escaping.
        write_reg(CFG_ORIGIN_RE, 32'(ONE / 4));
        send_pixel(5, 5);
        drain_results();

        for (int k = 0; k < PHASES; k++) begin
            pick_plane(k % 3, span);
            run_phase(t_idle_mode'(k % 4), PHASE_PIXELS, span);
        end

        write_plane(ORIGIN_RE_RST, ORIGIN_IM_RST, 32'(STEP_RE_RST), 32'(STEP_IM_RST),
                    32'd1023);
        run_phase(IDLE_BOTH, 40, 1023);
        write_reg(CFG_MAX_ITER, 32'd1);
        run_phase(IDLE_RECEIVER, 60, 1023);

        sender_gap_pct = 0;
        recv_stall_pct = 0;
        repeat (2 * int'(iter_limit) + 8) @(posedge i_clk);
        if (escape_q.size() != 0) begin
            error_count += escape_q.size();
            $display("%0t: %0d expected result words never arrived, expected 0, actual %0d",
                     $time, escape_q.size(), escape_q.size());
        end

        $display("Ran %0d pixel words over %0d register settings, including saturated planes",
                 pixels_sent, planes_used);
        $display("and the zero, one and 1023 iteration limits; %0d results checked, %0d inside.",
                 results_seen, inside_seen);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ mandelbrot_escape_iteration.f @@
rtl/mei_pkg.sv
rtl/mei_front.sv
rtl/mei_queue.sv
rtl/mei_back.sv
rtl/mandelbrot_escape_iteration.sv
tb/tb_mandelbrot_escape_iteration.sv
